[rtl/uiht_pkg.sv]
// Shared types, codes and defaults of the unique ID handle table.
package uiht_pkg;

	localparam int MAX_IDS_DEFAULT     = 256;
	localparam int HANDLE_BITS_DEFAULT = 32;
	localparam int CFG_ADDR_BITS       = 3;
	localparam logic [8:0] ID_LIMIT_RESET = 9'd256;

	// Command codes.
	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_GET    = 2'd2;

	// Status codes.
	localparam logic [2:0] STAT_NEW     = 3'd0;
	localparam logic [2:0] STAT_PRESENT = 3'd1;
	localparam logic [2:0] STAT_FULL    = 3'd2;
	localparam logic [2:0] STAT_DEAD    = 3'd3;
	localparam logic [2:0] STAT_ABSENT  = 3'd4;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] object_handle;
		logic        object_alive;
		logic [7:0]  lookup_id;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  result_id;
		logic        id_valid;
		logic [31:0] found_handle;
		logic [2:0]  status;
	} out_word_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_SCAN,
		S_DECIDE,
		S_RESP
	} state_t;

endpackage

[rtl/unique_id_handle_table.sv]
// Top level of the unique ID handle table: ID allocator over one entry memory.
// The block maps small IDs to object handles. An input word carries a command:
// add a handle, remove an ID, or get the handle stored at an ID. Each input word
// produces exactly one output word. Both channels use valid/ready; a word moves
// at a clock edge where valid and ready are both high.
// All table state sits in one synchronous memory of MAX_IDS entries, each an
// occupied bit and a handle, with a registered read port. An add reads every
// entry once, in ID order, to find a duplicate handle and, in the same pass,
// the first free ID below the limit at or after the rotating start point and
// the first free ID below that point; it then writes the new entry. The single
// memory read port sets the length of an add. An add that is refused early
// (dead object, table full) and a command with an ID outside the table skip
// the memory; remove and get read their entry once.
// One word is worked on at a time; the next input word is taken once the
// current one's result sits in the output register.
// After reset, a clearing pass walks the whole memory and marks
// every entry free; no input word is accepted meanwhile, while configuration
// writes are taken. If the receiver stalls, the output word holds and the block
// still accepts and works on one further word, which then waits for the output
// register. The id_limit register is at byte address 0 of the APB-style port.
module unique_id_handle_table #(
	parameter int MAX_IDS     = uiht_pkg::MAX_IDS_DEFAULT,
	parameter int HANDLE_BITS = uiht_pkg::HANDLE_BITS_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  uiht_pkg::in_word_t                 in_word,
	output logic                               out_valid,
	input  logic                               out_ready,
	output uiht_pkg::out_word_t                out_word,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [uiht_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	// Index width, and one more bit for counts and limits that reach MAX_IDS.
	localparam int IW  = $clog2(MAX_IDS);
	localparam int IW1 = IW + 1;
	// Stored handle width: handles are compared and kept masked to HANDLE_BITS.
	localparam int HW  = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
	localparam logic [IW-1:0] LAST_ID = IW'(MAX_IDS - 1);
	localparam logic [IW1-1:0] MAX_CNT = IW1'(MAX_IDS);

	uiht_pkg::state_t state_q, state_d;

	// Configuration.
	logic [8:0]     limit_q;
	logic [IW1-1:0] lim;
	logic           cfg_wr;

	// Entry memory: bit HW is the occupied flag, the rest the handle.
	logic [HW:0]    mem_q [MAX_IDS];
	logic           mem_we, mem_re;
	logic [IW-1:0]  mem_waddr, mem_raddr;
	logic [HW:0]    mem_wdata;
	logic [HW:0]    rd_data_s1;

	// Control and item registers.
	logic [IW-1:0]  clr_cnt_q;
	logic [IW1-1:0] scan_cnt_q;
	logic [IW-1:0]  idx_s1;
	logic           vld_s1;
	logic [1:0]     cmd_q;
	logic [HW-1:0]  handle_q;
	logic [IW-1:0]  id_addr_q;
	logic [IW-1:0]  start_q;
	logic [IW-1:0]  next_id_q;
	logic [IW1-1:0] count_q;

	// Search results gathered during the scan.
	logic           dup_found_q, ge_found_q, lt_found_q;
	logic [IW-1:0]  dup_id_q, ge_id_q, lt_id_q;

	uiht_pkg::out_word_t res_q;
	uiht_pkg::out_word_t out_word_q;
	logic                out_valid_q;

	logic           in_fire;
	logic           in_range;
	logic           rd_occ;
	logic [HW-1:0]  rd_handle;
	logic           free_found;
	logic [IW-1:0]  pos;
	logic [IW1-1:0] pos_inc;
	logic           out_load;
	logic           scan_last;
	logic [2:0]     acc_status;

	// The effective limit: zero acts as one, anything above the table depth
	// acts as the depth.
	always_comb begin
		if (limit_q == 9'd0) begin
			lim = IW1'(1);
		end else if (32'(limit_q) > 32'(MAX_IDS)) begin
			lim = MAX_CNT;
		end else begin
			lim = IW1'(limit_q);
		end
	end

	assign cfg_wr = psel & penable & pwrite & ~paddr[2];
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : 32'(limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= uiht_pkg::ID_LIMIT_RESET;
		end else if (cfg_wr) begin
			limit_q <= pwdata[8:0];
		end
	end

	assign in_fire   = in_valid & in_ready;
	assign in_range  = 32'(in_word.lookup_id) < 32'(MAX_IDS);
	assign rd_occ    = rd_data_s1[HW];
	assign rd_handle = rd_data_s1[HW-1:0];
	assign scan_last = vld_s1 && (idx_s1 == LAST_ID);

	// The cyclic search wins at the first free ID at or after the start point;
	// failing that, the first free ID below it.
	assign free_found = ge_found_q | lt_found_q;
	assign pos        = ge_found_q ? ge_id_q : lt_id_q;
	assign pos_inc    = {1'b0, pos} + IW1'(1);
	assign out_load   = (state_q == uiht_pkg::S_RESP) && (!out_valid_q || out_ready);

	// Status that an accepted word starts with: an add refused up front is final here,
	// everything else is settled later or stays absent.
	always_comb begin
		acc_status = uiht_pkg::STAT_ABSENT;
		if (in_word.cmd == uiht_pkg::CMD_ADD) begin
			if (!in_word.object_alive) begin
				acc_status = uiht_pkg::STAT_DEAD;
			end else if (count_q >= lim) begin
				acc_status = uiht_pkg::STAT_FULL;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			uiht_pkg::S_CLEAR: begin
				if (clr_cnt_q == LAST_ID) state_d = uiht_pkg::S_IDLE;
			end
			uiht_pkg::S_IDLE: begin
				if (in_fire) begin
					case (in_word.cmd)
						uiht_pkg::CMD_ADD: begin
							if (!in_word.object_alive || count_q >= lim) begin
								state_d = uiht_pkg::S_RESP;
							end else begin
								state_d = uiht_pkg::S_SCAN;
							end
						end
						uiht_pkg::CMD_REMOVE, uiht_pkg::CMD_GET: begin
							state_d = in_range ? uiht_pkg::S_LOOK : uiht_pkg::S_RESP;
						end
						default: state_d = uiht_pkg::S_RESP;
					endcase
				end
			end
			uiht_pkg::S_SCAN: begin
				if (scan_last) state_d = uiht_pkg::S_DECIDE;
			end
			uiht_pkg::S_LOOK:   state_d = uiht_pkg::S_RESP;
			uiht_pkg::S_DECIDE: state_d = uiht_pkg::S_RESP;
			uiht_pkg::S_RESP: begin
				if (out_load) state_d = uiht_pkg::S_IDLE;
			end
			default: state_d = uiht_pkg::S_CLEAR;
		endcase
	end

	// Handshake and memory port control.
	always_comb begin
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = clr_cnt_q;
		mem_raddr = IW'(in_word.lookup_id);
		mem_wdata = '0;
		case (state_q)
			uiht_pkg::S_CLEAR: begin
				mem_we = 1'b1;
			end
			uiht_pkg::S_IDLE: begin
				in_ready = 1'b1;
				mem_re   = in_valid && in_range &&
					(in_word.cmd == uiht_pkg::CMD_REMOVE || in_word.cmd == uiht_pkg::CMD_GET);
			end
			uiht_pkg::S_SCAN: begin
				mem_re    = scan_cnt_q != MAX_CNT;
				mem_raddr = scan_cnt_q[IW-1:0];
			end
			uiht_pkg::S_LOOK: begin
				mem_we    = (cmd_q == uiht_pkg::CMD_REMOVE) && rd_occ;
				mem_waddr = id_addr_q;
			end
			uiht_pkg::S_DECIDE: begin
				mem_we    = !dup_found_q && free_found;
				mem_waddr = pos;
				mem_wdata = {1'b1, handle_q};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Entry memory with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_waddr] <= mem_wdata;
		if (mem_re) rd_data_s1 <= mem_q[mem_raddr];
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= uiht_pkg::S_CLEAR;
			clr_cnt_q   <= '0;
			scan_cnt_q  <= '0;
			vld_s1      <= 1'b0;
			next_id_q   <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			dup_found_q <= 1'b0;
			ge_found_q  <= 1'b0;
			lt_found_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == uiht_pkg::S_SCAN) && mem_re;

			if (state_q == uiht_pkg::S_CLEAR) clr_cnt_q <= clr_cnt_q + IW'(1);

			if (in_fire) begin
				scan_cnt_q  <= '0;
				dup_found_q <= 1'b0;
				ge_found_q  <= 1'b0;
				lt_found_q  <= 1'b0;
			end else if (state_q == uiht_pkg::S_SCAN && mem_re) begin
				scan_cnt_q <= scan_cnt_q + IW1'(1);
			end

			// The lowest matching ID wins, so only the first hit of each kind is kept.
			if (state_q == uiht_pkg::S_SCAN && vld_s1) begin
				if (rd_occ && rd_handle == handle_q && !dup_found_q) begin
					dup_found_q <= 1'b1;
				end
				if (!rd_occ && {1'b0, idx_s1} < lim && idx_s1 >= start_q && !ge_found_q) begin
					ge_found_q <= 1'b1;
				end
				if (!rd_occ && idx_s1 < start_q && !lt_found_q) begin
					lt_found_q <= 1'b1;
				end
			end

			if (state_q == uiht_pkg::S_LOOK && mem_we && count_q != '0) begin
				count_q <= count_q - IW1'(1);
			end

			if (state_q == uiht_pkg::S_DECIDE && mem_we) begin
				count_q   <= count_q + IW1'(1);
				next_id_q <= (pos_inc >= lim) ? '0 : pos_inc[IW-1:0];
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item payload, scan positions and result words.
	always_ff @(posedge clk) begin
		idx_s1 <= scan_cnt_q[IW-1:0];

		if (in_fire) begin
			cmd_q     <= in_word.cmd;
			handle_q  <= in_word.object_handle[HW-1:0];
			id_addr_q <= IW'(in_word.lookup_id);
			start_q   <= ({1'b0, next_id_q} < lim) ? next_id_q : '0;
			res_q     <= '{result_id: 8'd0, id_valid: 1'b0, found_handle: 32'd0,
				status: acc_status};
		end

		if (state_q == uiht_pkg::S_SCAN && vld_s1) begin
			if (rd_occ && rd_handle == handle_q && !dup_found_q) dup_id_q <= idx_s1;
			if (!rd_occ && {1'b0, idx_s1} < lim && idx_s1 >= start_q && !ge_found_q) begin
				ge_id_q <= idx_s1;
			end
			if (!rd_occ && idx_s1 < start_q && !lt_found_q) lt_id_q <= idx_s1;
		end

		if (state_q == uiht_pkg::S_LOOK && cmd_q == uiht_pkg::CMD_GET && rd_occ) begin
			res_q.status       <= uiht_pkg::STAT_PRESENT;
			res_q.found_handle <= 32'(rd_handle);
		end

		if (state_q == uiht_pkg::S_DECIDE) begin
			if (dup_found_q) begin
				res_q.status    <= uiht_pkg::STAT_PRESENT;
				res_q.id_valid  <= 1'b1;
				res_q.result_id <= 8'(dup_id_q);
			end else if (free_found) begin
				res_q.status    <= uiht_pkg::STAT_NEW;
				res_q.id_valid  <= 1'b1;
				res_q.result_id <= 8'(pos);
			end else begin
				res_q.status <= uiht_pkg::STAT_FULL;
			end
		end

		if (out_load) out_word_q <= res_q;
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

[rtl/uiht_checker.sv]
// Port-level checker for the unique ID handle table, with its bind.
module uiht_port_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input uiht_pkg::out_word_t out_word
);

	// A stalled output word holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	// Only one word is worked on at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after an accept");

	// A valid ID comes only with a new or present status, and an invalid one reads zero.
	a_id_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_word.id_valid &&
			(out_word.status == uiht_pkg::STAT_NEW ||
			 out_word.status == uiht_pkg::STAT_PRESENT)) ||
			(!out_word.id_valid && out_word.result_id == 8'd0))
		else $error("ID and status disagree");

	// A handle is returned only by a successful get.
	a_handle_get: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.found_handle != 32'd0 |->
			out_word.status == uiht_pkg::STAT_PRESENT && !out_word.id_valid)
		else $error("handle returned outside a successful get");

endmodule

bind unique_id_handle_table uiht_port_checker u_uiht_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);

[dv/uiht_checker.sv]
// Response checker for the unique ID handle table: watches both channels and the register port.
`timescale 1ns / 100ps

module uiht_checker #(
	parameter logic [uiht_pkg::CFG_ADDR_BITS-1:0] LIMIT_ADDR = '0
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  uiht_pkg::in_word_t                 in_word,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  uiht_pkg::out_word_t                out_word,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [uiht_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  logic [31:0]                        pwdata,
	input  logic                               pready,
	output int                                 error_count,
	output int                                 responses_due
);
	import uiht_pkg::*;

	localparam int MAX_IDS = MAX_IDS_DEFAULT;

	// Shadow copy of the table and its configuration.
	bit          occupied [MAX_IDS];
	logic [31:0] stored_handle [MAX_IDS];
	int          next_id;
	int          entry_count;
	logic [8:0]  id_limit;

	out_word_t due_responses [$];
	out_word_t want;

	function automatic out_word_t predict_table_response(input in_word_t w);
		out_word_t r;
		int        lim;
		int        pos;
		bit        done;
		r        = '0;
		r.status = STAT_ABSENT;
		done     = 1'b0;
		lim      = (id_limit == 0) ? 1 : ((id_limit > MAX_IDS) ? MAX_IDS : int'(id_limit));
		case (w.cmd)
			CMD_ADD: begin
				if (!w.object_alive) begin
					r.status = STAT_DEAD;
					done     = 1'b1;
				end else if (entry_count >= lim) begin
					r.status = STAT_FULL;
					done     = 1'b1;
				end
				// The duplicate scan covers the whole table, also above the limit.
				for (int i = 0; i < MAX_IDS && !done; i++) begin
					if (occupied[i] && stored_handle[i] == w.object_handle) begin
						r.result_id = i[7:0];
						r.id_valid  = 1'b1;
						r.status    = STAT_PRESENT;
						done        = 1'b1;
					end
				end
				pos = (next_id < lim) ? next_id : 0;
				for (int i = 0; i < lim && !done; i++) begin
					if (!occupied[pos]) begin
						occupied[pos]      = 1'b1;
						stored_handle[pos] = w.object_handle;
						entry_count++;
						next_id = (pos + 1 >= lim) ? 0 : pos + 1;
						r.result_id = pos[7:0];
						r.id_valid  = 1'b1;
						r.status    = STAT_NEW;
						done        = 1'b1;
					end else begin
						pos = (pos + 1 >= lim) ? 0 : pos + 1;
					end
				end
				if (!done) r.status = STAT_FULL;
			end
			CMD_REMOVE: begin
				if (occupied[w.lookup_id]) begin
					occupied[w.lookup_id] = 1'b0;
					if (entry_count > 0) entry_count--;
				end
			end
			CMD_GET: begin
				if (occupied[w.lookup_id]) begin
					r.status       = STAT_PRESENT;
					r.found_handle = stored_handle[w.lookup_id];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_IDS; i++) occupied[i] = 1'b0;
			next_id     = 0;
			entry_count = 0;
			id_limit    = ID_LIMIT_RESET;
			due_responses.delete();
			responses_due = 0;
			error_count   = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR)
				id_limit = pwdata[8:0];
			// A response word can only belong to a command taken at an earlier edge.
			if (out_valid && out_ready) begin
				if (due_responses.size() == 0) begin
					if (error_count < 10)
						$display("%0t: response word with no command outstanding: %h",
							$time, out_word);
					error_count++;
				end else begin
					want = due_responses.pop_front();
					if (out_word.result_id !== want.result_id ||
						out_word.id_valid !== want.id_valid ||
						out_word.found_handle !== want.found_handle ||
						out_word.status !== want.status) begin
						if (error_count < 10) begin
							$display("%0t: response mismatch: expected id=%0d valid=%0b handle=%h status=%0d",
								$time, want.result_id, want.id_valid,
								want.found_handle, want.status);
							$display("    got id=%0d valid=%0b handle=%h status=%0d",
								out_word.result_id, out_word.id_valid,
								out_word.found_handle, out_word.status);
						end
						error_count++;
					end
				end
			end
			if (in_valid && in_ready)
				due_responses.push_back(predict_table_response(in_word));
			responses_due = due_responses.size();
		end
	end

endmodule

[dv/tb_top.sv]
// Testbench top for the unique ID handle table: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
	import uiht_pkg::*;

	// Command code 3 is not defined by the block; it must answer as absent and change nothing.
	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam logic [CFG_ADDR_BITS-1:0] ID_LIMIT_ADDR = '0;

	// An add reads every entry and the clearing pass after reset walks the whole memory; the
	// watchdog limit lies well above both, so reaching it with no word moving means the block is stuck.
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 300;
	localparam int SEGMENTS       = 7;
	localparam int SEGMENT_ITEMS  = 118;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_word_t    in_word;
	logic        out_valid;
	logic        out_ready;
	out_word_t   out_word;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [CFG_ADDR_BITS-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int error_count;
	int responses_due;
	int send_gap_pct;
	int recv_gap_pct;
	int stall_cycles = 0;

	// Limit as last written, so that random IDs can be aimed at the live part of the table.
	logic [8:0]  cur_limit;
	// A small set of handles that come back often, so that duplicates are frequent.
	logic [31:0] handle_pool [16];

	unique_id_handle_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	uiht_checker #(
		.LIMIT_ADDR (ID_LIMIT_ADDR)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_word       (in_word),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_word      (out_word),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.error_count   (error_count),
		.responses_due (responses_due)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The receiver decides at every falling edge whether it takes a word at the next rising edge.
	always @(negedge clk) begin
		out_ready = ($urandom_range(0, 99) >= recv_gap_pct);
	end

	// Watchdog: any cycle in which no word moves on either channel counts toward the limit.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("** unique_id_handle_table: FAILED **");
			$finish;
		end
	end

	function automatic in_word_t make_command(input logic [1:0] cmd, input logic [31:0] handle,
		input logic alive, input logic [7:0] id);
		in_word_t w;
		w.cmd           = cmd;
		w.object_handle = handle;
		w.object_alive  = alive;
		w.lookup_id     = id;
		return w;
	endfunction

	// Random command: adds, removes and gets with handles often from the pool and IDs mostly up to
	// the limit, mixed to keep the table churning, and a few dead or unknown ones.
	// Fields a command ignores still get random values.
	function automatic in_word_t random_command();
		in_word_t w;
		int       lim;
		int       sel;
		lim = (cur_limit == 0) ? 1 : ((cur_limit > 256) ? 256 : int'(cur_limit));
		if ($urandom_range(0, 99) < 60)
			w.object_handle = handle_pool[$urandom_range(0, 15)];
		else
			w.object_handle = $urandom();
		w.object_alive = ($urandom_range(0, 99) < 92);
		if ($urandom_range(0, 99) < 80)
			w.lookup_id = $urandom_range(0, (lim > 255) ? 255 : lim);
		else
			w.lookup_id = $urandom_range(0, 255);
		sel = $urandom_range(0, 99);
		if (sel < 45)
			w.cmd = CMD_ADD;
		else if (sel < 70)
			w.cmd = CMD_REMOVE;
		else if (sel < 96)
			w.cmd = CMD_GET;
		else
			w.cmd = CMD_NOP;
		return w;
	endfunction

	// Present one command word and hold it until the block takes it. Idle cycles before the
	// word are drawn from the sender's gap rate. On return the caller drives the next word
	// or lowers valid in the same time step.
	task automatic send_command(input in_word_t w);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_word  = w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Stop sending and wait until every predicted response word has come back.
	task automatic wait_for_responses();
		in_valid = 1'b0;
		while (responses_due != 0) @(negedge clk);
	endtask

	// Register write: setup cycle, then access cycle; the write lands at the rising edge that ends the access cycle.
	task automatic write_id_limit(input logic [8:0] value);
		in_valid = 1'b0;
		psel     = 1'b1;
		penable  = 1'b0;
		pwrite   = 1'b1;
		paddr    = ID_LIMIT_ADDR;
		pwdata   = {23'd0, value};
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		cur_limit = value;
	endtask

	initial begin
		logic [8:0] segment_limits [SEGMENTS];

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_word      = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		send_gap_pct = 20;
		recv_gap_pct = 81;
		cur_limit    = ID_LIMIT_RESET;
		handle_pool[0] = 32'h0000_0000;
		handle_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < 16; i++) handle_pool[i] = $urandom();
		// Extremes of the limit: zero acts as one, above the table size acts as the table size.
		segment_limits = '{9'd0, 9'd3, 9'd256, 9'd17, 9'd511, 9'd1, 9'd8};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part with a limit of four so that the table fills quickly. The write is
		// taken during the clearing pass; the first command waits until the pass is over.
		write_id_limit(9'd4);
		send_command(make_command(CMD_ADD, 32'hFFFF_FFFF, 1'b0, 8'd0));   // dead object
		send_command(make_command(CMD_ADD, 32'h0000_0000, 1'b1, 8'd0));   // new id 0
		send_command(make_command(CMD_ADD, 32'hFFFF_FFFF, 1'b1, 8'd255)); // new id 1
		send_command(make_command(CMD_ADD, 32'hFFFF_FFFF, 1'b1, 8'd0));   // already present
		send_command(make_command(CMD_GET, 32'h0000_0000, 1'b0, 8'd1));
		send_command(make_command(CMD_GET, 32'hFFFF_FFFF, 1'b1, 8'd255)); // absent, top ID
		send_command(make_command(CMD_ADD, 32'hA5A5_A5A5, 1'b1, 8'd0));
		// This one takes the last ID below the limit, so the counter wraps to zero.
		send_command(make_command(CMD_ADD, 32'h5A5A_5A5A, 1'b1, 8'd0));
		send_command(make_command(CMD_ADD, 32'h1234_5678, 1'b1, 8'd0));   // table full
		// A handle that is already stored is still refused as full when the table is full.
		send_command(make_command(CMD_ADD, 32'h0000_0000, 1'b1, 8'd0));
		send_command(make_command(CMD_REMOVE, 32'hFFFF_FFFF, 1'b1, 8'd1));
		send_command(make_command(CMD_REMOVE, 32'h0000_0000, 1'b0, 8'd1)); // already free
		send_command(make_command(CMD_REMOVE, 32'h0000_0000, 1'b0, 8'd255));
		send_command(make_command(CMD_NOP, 32'hFFFF_FFFF, 1'b1, 8'd255));
		// The search starts at the counter (zero), skips the taken ID and takes ID 1.
		send_command(make_command(CMD_ADD, 32'h8000_0001, 1'b1, 8'd0));
		send_command(make_command(CMD_REMOVE, 32'h0000_0000, 1'b1, 8'd0));

		// Lower the limit below the counter and below stored entries: the search must
		// restart at zero, and entries above the limit still count until removed.
		wait_for_responses();
		write_id_limit(9'd2);
		send_command(make_command(CMD_ADD, 32'h0000_0042, 1'b1, 8'd0));   // full: 3 stored
		send_command(make_command(CMD_REMOVE, 32'h0000_0000, 1'b0, 8'd2));
		send_command(make_command(CMD_REMOVE, 32'h0000_0000, 1'b0, 8'd3));
		send_command(make_command(CMD_ADD, 32'h0000_FFFF, 1'b1, 8'd0));
		send_command(make_command(CMD_GET, 32'h0000_0000, 1'b0, 8'd0));
		send_command(make_command(CMD_GET, 32'h0000_0000, 1'b0, 8'd2));   // above the limit
		send_command(make_command(CMD_REMOVE, 32'h0000_0000, 1'b0, 8'd1));

		// Random part in segments, each with its own limit. The first two segments have a
		// slow receiver, the next two a slow sender, the rest run at full rate.
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			wait_for_responses();
			if (seg < 2) begin
				send_gap_pct = 20;
				recv_gap_pct = 81;
			end else if (seg < 4) begin
				send_gap_pct = 81;
				recv_gap_pct = 20;
			end else begin
				send_gap_pct = 0;
				recv_gap_pct = 0;
			end
			write_id_limit(segment_limits[seg]);
			for (int n = 0; n < SEGMENT_ITEMS; n++) begin
				// Halfway through, let the block run completely dry before going on.
				if (n == SEGMENT_ITEMS / 2) wait_for_responses();
				send_command(random_command());
			end
		end

		wait_for_responses();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (error_count == 0 && responses_due == 0)
			$display("** unique_id_handle_table: PASSED **");
		else
			$display("** unique_id_handle_table: FAILED **");
		$finish;
	end

endmodule
